// ----- rtl/sbcr_pkg.sv -----
package sbcr_pkg;

  // default geometry
  localparam int DEF_NUM_BANDS = 16;
  localparam int DEF_NUM_ROWS  = 16;

  // input action codes
  localparam logic [1:0] ACT_BAND  = 2'd0;
  localparam logic [1:0] ACT_FRAME = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // display modes
  localparam logic [1:0] MODE_RAINBOW  = 2'd0;
  localparam logic [1:0] MODE_GRADIENT = 2'd1;
  localparam logic [1:0] MODE_HUEROW   = 2'd2;
  localparam logic [1:0] MODE_DOT      = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_DECAY = 2'd1;
  localparam logic [1:0] CFG_COLOR = 2'd2;

  // register reset values
  localparam logic [1:0]  RST_MODE  = MODE_RAINBOW;
  localparam logic [15:0] RST_DECAY = 16'd70;
  localparam logic [15:0] RST_COLOR = 16'd10;

  // hue step between rows in the per-row hue mode
  localparam logic [15:0] ROW_HUE_STEP = 16'd20;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // input word taken this cycle
    logic peak;    // update held peak of the latched band
    logic mod_a;   // hue mod 360: subtract estimated multiple
    logic mod_b;   // hue mod 360: final correction, row counter cleared
    logic emit;    // load one pixel into the output register
    logic sweep;   // one step of the peak decay sweep
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic band_go;    // pending input is a band level in range
    logic decay_go;   // pending input is a frame end with decay due
    logic slot_free;  // output register can take a pixel
    logic row_last;   // current row is the bottom one
    logic sweep_done; // last sweep step
  } sts_t;

  // HSV to RGB at saturation and value 100, hue already reduced mod 360
  function automatic rgb_t hue_rgb(input logic [8:0] m);
    logic [2:0]  sec;
    logic [8:0]  base;
    logic [5:0]  rem;
    logic [8:0]  x_up;
    logic [8:0]  x_dn;
    logic [16:0] p_up;
    logic [16:0] p_dn;
    logic [7:0]  rise;
    logic [7:0]  fall;
    rgb_t        c;
    if (m >= 9'd300) begin
      sec = 3'd5; base = 9'd300;
    end else if (m >= 9'd240) begin
      sec = 3'd4; base = 9'd240;
    end else if (m >= 9'd180) begin
      sec = 3'd3; base = 9'd180;
    end else if (m >= 9'd120) begin
      sec = 3'd2; base = 9'd120;
    end else if (m >= 9'd60) begin
      sec = 3'd1; base = 9'd60;
    end else begin
      sec = 3'd0; base = 9'd0;
    end
    rem  = 6'(m - base);
    // 100*r/60 = 5*r/3; divide by 3 as *171 >> 9 (exact below 512)
    x_up = 9'(9'(rem) * 9'd5);
    x_dn = 9'(9'(7'd60 - 7'(rem)) * 9'd5);
    p_up = 17'(x_up) * 17'd171;
    p_dn = 17'(x_dn) * 17'd171;
    rise = 8'(p_up >> 9);
    fall = 8'(p_dn >> 9);
    case (sec)
      3'd0:    c = '{red: 8'd100, green: rise,   blue: 8'd0};
      3'd1:    c = '{red: fall,   green: 8'd100, blue: 8'd0};
      3'd2:    c = '{red: 8'd0,   green: 8'd100, blue: rise};
      3'd3:    c = '{red: 8'd0,   green: fall,   blue: 8'd100};
      3'd4:    c = '{red: rise,   green: 8'd0,   blue: 8'd100};
      default: c = '{red: 8'd100, green: 8'd0,   blue: fall};
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/spectrum_bar_column_renderer.sv -----
// Spectrum bar column renderer with peak hold.
// Input channel (in_*): one word per action. A band level word clamps the
// level to the row count, raises that band's held peak and renders the band's
// screen column as NUM_ROWS pixel words, top row first, out_last on the
// bottom row. A frame end word steps all held peaks down and advances the hue
// phase when their intervals have elapsed; a tick word advances the
// millisecond count. Only band words produce output.
// Config channel (cfg_*): always ready; index 0 mode, 1 decay interval,
// 2 color interval; other indexes are dropped.
// Sequence: a taken band word passes the PEAK, MODA and MODB states, then
// pixels leave one per cycle while out_ready allows. A frame end with decay
// due walks the peak memory in the SWEEP state. Tick and other frame end
// words are taken without leaving idle.
// Output stall: the pixel register holds its word until out_ready; rendering
// pauses meanwhile. in_ready rises as soon as the last pixel is loaded.
// Reset: peaks, time marks and hue phase clear; registers return to mode 0,
// decay 70 ms, color 10 ms. No clearing pass is needed.
module spectrum_bar_column_renderer
  import sbcr_pkg::*;
#(
  parameter int NUM_BANDS = DEF_NUM_BANDS,
  parameter int NUM_ROWS  = DEF_NUM_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [5:0]  in_band_index,
  input  logic [7:0]  in_band_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_column,
  output logic [5:0]  out_row,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sbcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbcr_dpath #(
    .NUM_BANDS (NUM_BANDS),
    .NUM_ROWS  (NUM_ROWS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_action),
    .in_band_index (in_band_index),
    .in_band_level (in_band_level),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_column    (out_column),
    .out_row       (out_row),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_last      (out_last)
  );

endmodule

// ----- rtl/sbcr_ctrl.sv -----
module sbcr_ctrl
  import sbcr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PEAK  = 3'd1;
  localparam logic [2:0] S_MODA  = 3'd2;
  localparam logic [2:0] S_MODB  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_SWEEP = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // commands
  always_comb begin
    cmd        = '0;
    cmd.accept = in_valid && in_ready;
    cmd.peak   = (state_r == S_PEAK);
    cmd.mod_a  = (state_r == S_MODA);
    cmd.mod_b  = (state_r == S_MODB);
    cmd.emit   = (state_r == S_EMIT) && sts.slot_free;
    cmd.sweep  = (state_r == S_SWEEP);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept && sts.band_go) begin
          state_nxt = S_PEAK;
        end else if (cmd.accept && sts.decay_go) begin
          state_nxt = S_SWEEP;
        end
      end
      S_PEAK:  state_nxt = S_MODA;
      S_MODA:  state_nxt = S_MODB;
      S_MODB:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (cmd.emit && sts.row_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (sts.sweep_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/sbcr_dpath.sv -----
module sbcr_dpath
  import sbcr_pkg::*;
#(
  parameter int NUM_BANDS = DEF_NUM_BANDS,
  parameter int NUM_ROWS  = DEF_NUM_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  in_action,
  input  logic [5:0]  in_band_index,
  input  logic [7:0]  in_band_level,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_column,
  output logic [5:0]  out_row,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last
);

  localparam int BAW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int RW  = $clog2(NUM_ROWS);
  localparam logic [RW-1:0]  ROW_MAX   = RW'(NUM_ROWS - 1);
  localparam logic [6:0]     LVL_MAX   = 7'(NUM_ROWS);
  localparam logic [15:0]    ROW_HUE0  = 16'((NUM_ROWS - 1) * 20);
  localparam logic [BAW:0]   SW_END    = (BAW + 1)'(NUM_BANDS);

  // constant tables: band base hue and gradient level
  logic [8:0] band_hue [NUM_BANDS];
  logic [7:0] grad_t   [NUM_ROWS];

  for (genvar g = 0; g < NUM_BANDS; g++) begin : g_bhue
    assign band_hue[g] = 9'((g * 360) / NUM_BANDS);
  end
  for (genvar g = 0; g < NUM_ROWS; g++) begin : g_grad
    assign grad_t[g] = 8'((g * 255) / (NUM_ROWS - 1));
  end

  // configuration and timing state
  logic [1:0]  mode_r;
  logic [15:0] decay_int_r;
  logic [15:0] color_int_r;
  logic [31:0] now_ms_r;
  logic [31:0] last_decay_r;
  logic [31:0] last_color_r;
  logic [15:0] phase_r;

  // held peak store
  logic [6:0]         pk_mem [NUM_BANDS];
  logic [NUM_BANDS-1:0] pk_vld_r;
  logic [6:0]         rd_data_r;
  logic               rd_vld_r;
  logic [BAW-1:0]     rd_addr;
  logic               wr_en;
  logic [BAW-1:0]     wr_addr;
  logic [6:0]         wr_data;
  logic [6:0]         rd_peak;

  // column state
  logic [BAW-1:0] band_r;
  logic [6:0]     level_r;
  logic [6:0]     peak_r;
  logic [15:0]    h_r;
  logic [15:0]    h_nxt;
  logic [29:0]    prod_r;
  logic [9:0]     mest_r;
  logic [8:0]     m_r;
  logic [8:0]     m_nxt;
  logic [RW-1:0]  row_r;
  logic [BAW:0]   sw_cnt_r;
  logic [BAW-1:0] sw_prev_r;
  logic           out_valid_r;

  logic        is_band;
  logic        decay_fire;
  logic        color_fire;
  logic [6:0]  lvl_clamp;
  logic [6:0]  pk_new;
  logic [7:0]  q_est;
  logic [RW-1:0] y;
  logic        in_bar;
  logic        on_peak;
  rgb_t        bar_c;
  rgb_t        px;
  logic [7:0]  dot_g;

  // input decode
  assign is_band    = (in_action == ACT_BAND) && (7'(in_band_index) < 7'(NUM_BANDS));
  assign decay_fire = (32'(now_ms_r - last_decay_r) >= 32'(decay_int_r));
  assign color_fire = (32'(now_ms_r - last_color_r) >= 32'(color_int_r));
  assign lvl_clamp  = (in_band_level > 8'(LVL_MAX)) ? LVL_MAX : in_band_level[6:0];

  assign sts.band_go    = is_band;
  assign sts.decay_go   = (in_action == ACT_FRAME) && decay_fire;
  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.row_last   = (row_r == ROW_MAX);
  assign sts.sweep_done = (sw_cnt_r == SW_END);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= RST_MODE;
      decay_int_r <= RST_DECAY;
      color_int_r <= RST_COLOR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:  mode_r      <= cfg_data[1:0];
        CFG_DECAY: decay_int_r <= cfg_data;
        CFG_COLOR: color_int_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // millisecond clock, interval marks and hue phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_ms_r     <= '0;
      last_decay_r <= '0;
      last_color_r <= '0;
      phase_r      <= '0;
    end else if (cmd.accept) begin
      if (in_action == ACT_TICK) begin
        now_ms_r <= now_ms_r + 32'd1;
      end
      if (in_action == ACT_FRAME) begin
        if (decay_fire) begin
          last_decay_r <= now_ms_r;
        end
        if (color_fire) begin
          last_color_r <= now_ms_r;
          phase_r      <= phase_r + 16'd1;
        end
      end
    end
  end

  // peak store ports: sweep address during the decay sweep, band index otherwise
  assign rd_addr = cmd.sweep ? sw_cnt_r[BAW-1:0] : in_band_index[BAW-1:0];
  assign rd_peak = rd_vld_r ? rd_data_r : 7'd0;
  assign pk_new  = (level_r > rd_peak) ? level_r : rd_peak;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = band_r;
    wr_data = pk_new;
    if (cmd.peak) begin
      wr_en = 1'b1;
    end else if (cmd.sweep && (sw_cnt_r != '0) && (rd_peak != 7'd0)) begin
      wr_en   = 1'b1;
      wr_addr = sw_prev_r;
      wr_data = rd_peak - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= pk_mem[rd_addr];
    if (wr_en) begin
      pk_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_vld_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= pk_vld_r[rd_addr];
      if (wr_en) begin
        pk_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_cnt_r <= '0;
    end else if (cmd.accept) begin
      sw_cnt_r <= '0;
    end else if (cmd.sweep) begin
      sw_cnt_r <= sw_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    sw_prev_r <= sw_cnt_r[BAW-1:0];
  end

  // per-row hue walk: step back 20, a 16-bit wrap shifts mod 360 by 16
  always_comb begin
    h_nxt = h_r - ROW_HUE_STEP;
    if (h_r >= ROW_HUE_STEP) begin
      m_nxt = (m_r >= 9'd20) ? (m_r - 9'd20) : (m_r + 9'd340);
    end else begin
      m_nxt = (m_r >= 9'd4) ? (m_r - 9'd4) : (m_r + 9'd356);
    end
  end

  // hue mod 360 via reciprocal 11650 / 2^22, at most one correction
  assign q_est = prod_r[29:22];

  always_ff @(posedge clk) begin
    if (cmd.accept && is_band) begin
      band_r  <= in_band_index[BAW-1:0];
      level_r <= lvl_clamp;
      h_r     <= (mode_r == MODE_HUEROW) ? (phase_r + ROW_HUE0)
                                         : (16'(band_hue[in_band_index[BAW-1:0]]) + phase_r);
    end else if (cmd.emit && (mode_r == MODE_HUEROW)) begin
      h_r <= h_nxt;
    end
    if (cmd.peak) begin
      peak_r <= pk_new;
      prod_r <= 30'(h_r) * 30'd11650;
    end
    if (cmd.mod_a) begin
      mest_r <= 10'(17'(h_r) - 17'(q_est) * 17'd360);
    end
    if (cmd.mod_b) begin
      m_r <= (mest_r >= 10'd360) ? 9'(mest_r - 10'd360) : mest_r[8:0];
    end else if (cmd.emit && (mode_r == MODE_HUEROW)) begin
      m_r <= m_nxt;
    end
  end

  // row counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (cmd.mod_b) begin
      row_r <= '0;
    end else if (cmd.emit) begin
      row_r <= row_r + 1'b1;
    end
  end

  // pixel colour of the current row
  assign y       = ROW_MAX - row_r;
  assign in_bar  = (7'(y) < level_r);
  assign on_peak = (7'(y) == peak_r);
  assign bar_c   = hue_rgb(m_r);
  assign dot_g   = 8'd255 - 8'(12'(peak_r) * 12'd20);

  always_comb begin
    px = '0;
    case (mode_r)
      MODE_RAINBOW: begin
        if (in_bar) px = bar_c;
        if (on_peak) px = '{red: 8'd150, green: 8'd150, blue: 8'd150};
      end
      MODE_GRADIENT: begin
        if (in_bar) px = '{red: grad_t[y], green: 8'd255 - grad_t[y], blue: 8'd100};
        if (on_peak) px = '{red: 8'd150, green: 8'd150, blue: 8'd150};
      end
      MODE_HUEROW: begin
        if (in_bar) px = bar_c;
      end
      default: begin
        if (on_peak) px = '{red: 8'd255, green: dot_g, blue: 8'd0};
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_column <= 6'(NUM_BANDS - 1) - 6'(band_r);
      out_row    <= 6'(row_r);
      out_red    <= px.red;
      out_green  <= px.green;
      out_blue   <= px.blue;
      out_last   <= (row_r == ROW_MAX);
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/sbcr_chk.sv -----
module sbcr_chk
  import sbcr_pkg::*;
#(
  parameter int NUM_ROWS = DEF_NUM_ROWS
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_column,
  input logic [5:0]  out_row,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic        out_last
);

  // stalled pixel word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_column)
      && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_last))
    else $error("pixel word changed while stalled");

  // a column streams without gaps, rows in order, same column
  a_col_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid
      && (out_row == 6'($past(out_row) + 6'd1)) && (out_column == $past(out_column)))
    else $error("column stream broken");

  // no new input word while a column is still being drawn
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken mid-column");

  // last marks exactly the bottom row
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_row == 6'(NUM_ROWS - 1))))
    else $error("last flag does not match bottom row");

endmodule

bind spectrum_bar_column_renderer sbcr_chk #(.NUM_ROWS(NUM_ROWS)) u_sbcr_chk (.*);
